### hw/rtl/ttag_pkg.sv
// shared types, codes and constants of the transaction tag allocator
package ttag_pkg;

   localparam int TAG_W          = 16;
   localparam int OWNER_W        = 8;
   localparam int KIND_W         = 2;
   localparam int STATUS_W       = 3;
   localparam int LIMIT_W        = 7;
   localparam int REQ_DATA_W     = 24;
   localparam int RSP_DATA_W     = 32;
   localparam int RSP_PAD_W      = RSP_DATA_W - OWNER_W - TAG_W - STATUS_W;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 16;

   localparam int POOL_DEPTH_DEF = 64;
   localparam int OWNER_BITS_DEF = 8;
   localparam int QUEUE_DEPTH    = 2;
   localparam int GROUP_W        = 8;
   localparam int GROUP_BIT_W    = $clog2(GROUP_W);

   localparam logic [LIMIT_W-1:0] TAG_LIMIT_RESET = 7'd64;

   // request kinds as they arrive on the bus
   localparam logic [KIND_W-1:0] KIND_ALLOC    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESPONSE = 2'd2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TAG_BASE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAG_LIMIT = 1'd1;

   typedef enum logic [1:0] {
      OP_ALLOC    = 2'd0,
      OP_RELEASE  = 2'd1,
      OP_RESPONSE = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_RANGE     = 3'd2,
      ST_NO_WAITER = 3'd3,
      ST_FREE_SLOT = 3'd4
   } status_type;

   // classified request as it sits in the queue
   typedef struct packed {
      op_type             op;
      logic [OWNER_W-1:0] owner_id;
      logic [TAG_W-1:0]   tag;
      logic [TAG_W-1:0]   offset;
      logic               below_base;
   } request_type;

endpackage

### hw/rtl/transaction_tag_allocator_unit.sv
// transaction tag allocator: allocate request tags, release them, match responses
// back end: allocate runs S_IDLE, S_SCAN, S_PICK; release/response run S_IDLE, S_LOOK
//   (two-step grouped search over the free-slot vector for allocate, owner store read otherwise);
//   it finishes one request before it pops the next, and pops only once the result register is free
// reset: synchronous; all slots free, pool size and counters zero, tag_base 0, tag_limit 64
//   owner store is not cleared; there is no clearing pass
module transaction_tag_allocator_unit #(
   parameter int POOL_DEPTH = ttag_pkg::POOL_DEPTH_DEF,
   parameter int OWNER_BITS = ttag_pkg::OWNER_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ttag_pkg::REQ_DATA_W-1:0]     req_tdata,   // owner_id[7:0], tag_in[23:8]
   input  logic [ttag_pkg::KIND_W-1:0]         req_tuser,   // kind[1:0]
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ttag_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // status[2:0], tag_out[18:3],
                                                            // owner_out[26:19], zero fill
   // register write port
   input  logic                                csr_we,
   input  logic [ttag_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ttag_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // configuration registers; the user must write them only while the unit is idle, not enforced here
   logic [ttag_pkg::TAG_W-1:0]    tag_base_ff, tag_base_in;
   logic [ttag_pkg::LIMIT_W-1:0]  tag_limit_ff, tag_limit_in;

   // front to queue, queue to back
   logic                          q_push, q_full, q_pop, q_empty;
   ttag_pkg::request_type         q_push_data, q_head;

   always_comb begin
      tag_base_in  = tag_base_ff;
      tag_limit_in = tag_limit_ff;
      if (csr_we) begin
         case (csr_index)
            ttag_pkg::CSR_TAG_BASE:  tag_base_in  = csr_wdata;
            ttag_pkg::CSR_TAG_LIMIT: tag_limit_in = csr_wdata[ttag_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_base_ff  <= '0;
         tag_limit_ff <= ttag_pkg::TAG_LIMIT_RESET;
      end else begin
         tag_base_ff  <= tag_base_in;
         tag_limit_ff <= tag_limit_in;
      end
   end

   // front: handshake, kind decode, offset from tag_base
   ttag_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .tag_base   (tag_base_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_push_data)
   );

   // decouples request intake from the slot engine
   ttag_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   // back: slot pool, search, owner store, result register
   ttag_back #(
      .POOL_DEPTH (POOL_DEPTH),
      .OWNER_BITS (OWNER_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .tag_base   (tag_base_ff),
      .tag_limit  (tag_limit_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### hw/rtl/ttag_front.sv
// front end: takes requests, classifies them and computes the slot offset
module ttag_front (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ttag_pkg::REQ_DATA_W-1:0]   req_tdata,   // owner_id, tag_in
   input  logic [ttag_pkg::KIND_W-1:0]       req_tuser,   // kind
   input  logic [ttag_pkg::TAG_W-1:0]        tag_base,
   input  logic                              q_full,
   output logic                              q_push,
   output ttag_pkg::request_type             q_data
);

   logic                         known_kind;
   logic [ttag_pkg::TAG_W-1:0]   tag;

   assign tag        = req_tdata[ttag_pkg::OWNER_W +: ttag_pkg::TAG_W];
   assign req_tready = !q_full;

   always_comb begin
      known_kind  = 1'b1;
      q_data.op   = ttag_pkg::OP_ALLOC;
      case (req_tuser)
         ttag_pkg::KIND_ALLOC:    q_data.op = ttag_pkg::OP_ALLOC;
         ttag_pkg::KIND_RELEASE:  q_data.op = ttag_pkg::OP_RELEASE;
         ttag_pkg::KIND_RESPONSE: q_data.op = ttag_pkg::OP_RESPONSE;
         default:                 known_kind = 1'b0;
      endcase
      q_data.owner_id   = req_tdata[ttag_pkg::OWNER_W-1:0];
      q_data.tag        = tag;
      q_data.offset     = tag - tag_base;
      q_data.below_base = (tag < tag_base);
   end

   // unknown kinds are taken and dropped without a result
   assign q_push = req_tvalid && !q_full && known_kind;

endmodule

### hw/rtl/ttag_queue.sv
// short request queue between front and back end
module ttag_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ttag_pkg::request_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output ttag_pkg::request_type head
);

   localparam int PTR_W = (ttag_pkg::QUEUE_DEPTH > 1) ? $clog2(ttag_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(ttag_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ttag_pkg::QUEUE_DEPTH - 1);

   ttag_pkg::request_type entries_ff [ttag_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(ttag_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/ttag_back.sv
// back end: slot pool state, free slot search, owner store and result register
module ttag_back #(
   parameter int POOL_DEPTH = ttag_pkg::POOL_DEPTH_DEF,
   parameter int OWNER_BITS = ttag_pkg::OWNER_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  ttag_pkg::request_type             q_head,
   output logic                              q_pop,
   input  logic [ttag_pkg::TAG_W-1:0]        tag_base,
   input  logic [ttag_pkg::LIMIT_W-1:0]      tag_limit,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ttag_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int IDX_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int SIZE_W    = $clog2(POOL_DEPTH + 1);
   localparam int NGRP      = (POOL_DEPTH + ttag_pkg::GROUP_W - 1) / ttag_pkg::GROUP_W;
   localparam int VEC_W     = NGRP * ttag_pkg::GROUP_W;
   localparam int GRP_IDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int PICK_W    = GRP_IDX_W + ttag_pkg::GROUP_BIT_W;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_PICK = 4'b0100,
      S_LOOK = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [POOL_DEPTH-1:0]         busy_v_ff, busy_v_in;
   logic [POOL_DEPTH-1:0]         ans_v_ff, ans_v_in;
   logic [SIZE_W-1:0]             busy_cnt_ff, busy_cnt_in;
   logic [SIZE_W-1:0]             active_ff, active_in;
   logic [IDX_W-1:0]              hint_ff, hint_in;

   ttag_pkg::op_type              op_ff, op_in;
   logic [OWNER_BITS-1:0]         owner_ff, owner_in;
   logic [ttag_pkg::TAG_W-1:0]    req_tag_ff, req_tag_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic                          range_ok_ff, range_ok_in;
   logic                          can_alloc_ff, can_alloc_in;
   logic [NGRP-1:0]               grp_hi_ff, grp_hi_in;
   logic [NGRP-1:0]               grp_all_ff, grp_all_in;
   logic [VEC_W-1:0]              hi_vec_ff, hi_vec_in;
   logic [VEC_W-1:0]              all_vec_ff, all_vec_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   ttag_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [ttag_pkg::TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;
   logic [ttag_pkg::OWNER_W-1:0]  rsp_owner_ff, rsp_owner_in;

   logic [OWNER_BITS-1:0]         owner_mem [POOL_DEPTH];
   logic [OWNER_BITS-1:0]         owner_rd_ff;
   logic [IDX_W-1:0]              rd_addr;
   logic                          mem_we;

   logic [SIZE_W-1:0]             cap_sz;
   logic [SIZE_W:0]               grown_w;
   logic [IDX_W-1:0]              start_idx;
   logic                          slot_busy, slot_ans;

   logic [GRP_IDX_W-1:0]          hi_grp, all_grp, sel_grp;
   logic                          any_hi;
   logic [ttag_pkg::GROUP_W-1:0]  grp_bits;
   logic [ttag_pkg::GROUP_BIT_W-1:0] sel_bit;
   logic [PICK_W-1:0]             pick_wide;
   logic [IDX_W-1:0]              pick_idx;
   logic                          found;

   // growth ceiling: tag_limit, never above the pool depth
   always_comb begin
      if (int'(tag_limit) < POOL_DEPTH) begin
         cap_sz = SIZE_W'(tag_limit);
      end else begin
         cap_sz = SIZE_W'(POOL_DEPTH);
      end
      grown_w = (active_ff == '0) ? (SIZE_W + 1)'(1) : {active_ff, 1'b0};
      if (grown_w > {1'b0, cap_sz}) begin
         grown_w = {1'b0, cap_sz};
      end
   end

   assign start_idx = (SIZE_W'(hint_ff) < active_ff) ? hint_ff : '0;

   // lowest group with a free slot at or above the hint (else lowest with any free slot), then lowest slot in it
   always_comb begin
      hi_grp  = '0;
      all_grp = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_hi_ff[g]) begin
            hi_grp = GRP_IDX_W'(g);
         end
         if (grp_all_ff[g]) begin
            all_grp = GRP_IDX_W'(g);
         end
      end
      any_hi  = |grp_hi_ff;
      sel_grp = any_hi ? hi_grp : all_grp;
      grp_bits = any_hi ? hi_vec_ff[hi_grp * ttag_pkg::GROUP_W +: ttag_pkg::GROUP_W]
                        : all_vec_ff[all_grp * ttag_pkg::GROUP_W +: ttag_pkg::GROUP_W];
      sel_bit = '0;
      for (int b = ttag_pkg::GROUP_W - 1; b >= 0; b--) begin
         if (grp_bits[b]) begin
            sel_bit = ttag_pkg::GROUP_BIT_W'(b);
         end
      end
      pick_wide = {sel_grp, sel_bit};
      pick_idx  = pick_wide[IDX_W-1:0];
      found     = can_alloc_ff && (|grp_all_ff);
   end

   // slot state seen by a release or response; only meaningful in range
   assign slot_busy = range_ok_ff && busy_v_ff[idx_ff];
   assign slot_ans  = range_ok_ff && ans_v_ff[idx_ff];
   assign rd_addr   = q_head.offset[IDX_W-1:0];

   always_comb begin
      state_in      = state_ff;
      busy_v_in     = busy_v_ff;
      ans_v_in      = ans_v_ff;
      busy_cnt_in   = busy_cnt_ff;
      active_in     = active_ff;
      hint_in       = hint_ff;
      op_in         = op_ff;
      owner_in      = owner_ff;
      req_tag_in    = req_tag_ff;
      idx_in        = idx_ff;
      range_ok_in   = range_ok_ff;
      can_alloc_in  = can_alloc_ff;
      grp_hi_in     = grp_hi_ff;
      grp_all_in    = grp_all_ff;
      hi_vec_in     = hi_vec_ff;
      all_vec_in    = all_vec_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_owner_in  = rsp_owner_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            // start only when the result register will be free
            if (!q_empty && (!rsp_valid_ff || rsp_tready)) begin
               q_pop       = 1'b1;
               op_in       = q_head.op;
               owner_in    = OWNER_BITS'(q_head.owner_id);
               req_tag_in  = q_head.tag;
               idx_in      = rd_addr;
               range_ok_in = !q_head.below_base &&
                             (q_head.offset < ttag_pkg::TAG_W'(active_ff));
               if (q_head.op == ttag_pkg::OP_ALLOC) begin
                  // every active slot busy and pool below its ceiling: grow and point the hint at the first new slot
                  if ((busy_cnt_ff >= active_ff) && (active_ff < cap_sz)) begin
                     hint_in   = active_ff[IDX_W-1:0];
                     active_in = grown_w[SIZE_W-1:0];
                  end
                  state_in = S_SCAN;
               end else begin
                  state_in = S_LOOK;
               end
            end
         end

         S_SCAN: begin
            for (int i = 0; i < VEC_W; i++) begin
               all_vec_in[i] = 1'b0;
               hi_vec_in[i]  = 1'b0;
               if (i < POOL_DEPTH) begin
                  all_vec_in[i] = (SIZE_W'(i) < active_ff) && !busy_v_ff[i];
                  hi_vec_in[i]  = all_vec_in[i] && (IDX_W'(i) >= start_idx);
               end
            end
            for (int g = 0; g < NGRP; g++) begin
               grp_hi_in[g]  = |hi_vec_in[g * ttag_pkg::GROUP_W +: ttag_pkg::GROUP_W];
               grp_all_in[g] = |all_vec_in[g * ttag_pkg::GROUP_W +: ttag_pkg::GROUP_W];
            end
            can_alloc_in = (busy_cnt_ff < active_ff);
            state_in     = S_PICK;
         end

         S_PICK: begin
            rsp_valid_in = 1'b1;
            if (found) begin
               busy_v_in[pick_idx] = 1'b1;
               ans_v_in[pick_idx]  = 1'b0;
               busy_cnt_in         = busy_cnt_ff + 1'b1;
               mem_we              = 1'b1;
               rsp_status_in       = ttag_pkg::ST_OK;
               rsp_tag_in          = tag_base + ttag_pkg::TAG_W'(pick_idx);
               rsp_owner_in        = ttag_pkg::OWNER_W'(owner_ff);
            end else begin
               rsp_status_in = ttag_pkg::ST_FULL;
               rsp_tag_in    = '0;
               rsp_owner_in  = '0;
            end
            state_in = S_IDLE;
         end

         S_LOOK: begin
            rsp_valid_in  = 1'b1;
            rsp_tag_in    = req_tag_ff;
            rsp_owner_in  = '0;
            rsp_status_in = ttag_pkg::ST_OK;
            if (!range_ok_ff) begin
               rsp_status_in = ttag_pkg::ST_RANGE;
            end else if (op_ff == ttag_pkg::OP_RELEASE) begin
               if (!slot_busy) begin
                  rsp_status_in = ttag_pkg::ST_FREE_SLOT;
               end else begin
                  // waiting or answered, freed either way
                  rsp_owner_in      = ttag_pkg::OWNER_W'(owner_rd_ff);
                  busy_v_in[idx_ff] = 1'b0;
                  ans_v_in[idx_ff]  = 1'b0;
                  if (busy_cnt_ff != '0) begin
                     busy_cnt_in = busy_cnt_ff - 1'b1;
                  end
                  hint_in = idx_ff;
               end
            end else begin
               if (!slot_busy || slot_ans) begin
                  rsp_status_in = ttag_pkg::ST_NO_WAITER;
               end else begin
                  rsp_owner_in     = ttag_pkg::OWNER_W'(owner_rd_ff);
                  ans_v_in[idx_ff] = 1'b1;
               end
            end
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_v_ff    <= '0;
         ans_v_ff     <= '0;
         busy_cnt_ff  <= '0;
         active_ff    <= '0;
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_v_ff    <= busy_v_in;
         ans_v_ff     <= ans_v_in;
         busy_cnt_ff  <= busy_cnt_in;
         active_ff    <= active_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      owner_ff      <= owner_in;
      req_tag_ff    <= req_tag_in;
      idx_ff        <= idx_in;
      range_ok_ff   <= range_ok_in;
      can_alloc_ff  <= can_alloc_in;
      grp_hi_ff     <= grp_hi_in;
      grp_all_ff    <= grp_all_in;
      hi_vec_ff     <= hi_vec_in;
      all_vec_ff    <= all_vec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_owner_ff  <= rsp_owner_in;
   end

   // owner store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         owner_mem[pick_idx] <= owner_ff;
      end
      owner_rd_ff <= owner_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{ttag_pkg::RSP_PAD_W{1'b0}}, rsp_owner_ff, rsp_tag_ff, rsp_status_ff};

endmodule
